>>> src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled at every rising edge outside reset.
`define ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion sampled at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/ynd_pkg.sv
package ynd_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int CFG_W    = 13;
  localparam int STRIDE_W = 14;
  localparam int DIM_W    = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);
  localparam int COL_W    = STRIDE_W;
  localparam int ROW_W    = DIM_W;
  localparam int NSR_W    = ROW_W + 1;
  localparam int COORD_W  = 12;
  localparam int PIX_W    = 8;
  localparam int DIV_CNT_W = $clog2(DIM_W + 1);

  localparam int NUM_REGS = 6;
  localparam int ADDR_W   = $clog2(4 * NUM_REGS);
  localparam int IDX_W    = ADDR_W - 2;
  localparam int DATA_W   = 32;

  localparam logic [IDX_W-1:0] REG_SRC_WIDTH     = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_SRC_HEIGHT    = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_LUMA_STRIDE   = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_CHROMA_STRIDE = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_DST_WIDTH     = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_DST_HEIGHT    = IDX_W'(5);

  localparam logic [CFG_W-1:0]    RST_SRC_WIDTH     = CFG_W'(640);
  localparam logic [CFG_W-1:0]    RST_SRC_HEIGHT    = CFG_W'(480);
  localparam logic [STRIDE_W-1:0] RST_LUMA_STRIDE   = STRIDE_W'(640);
  localparam logic [CFG_W-1:0]    RST_CHROMA_STRIDE = CFG_W'(320);
  localparam logic [CFG_W-1:0]    RST_DST_WIDTH     = CFG_W'(320);
  localparam logic [CFG_W-1:0]    RST_DST_HEIGHT    = CFG_W'(240);

  localparam logic [1:0] PLANE_Y    = 2'd0;
  localparam logic [1:0] PLANE_U    = 2'd1;
  localparam logic [1:0] PLANE_V    = 2'd2;
  localparam logic [1:0] PLANE_IDLE = 2'd3;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [DIM_W-1:0]    sw;
    logic [DIM_W-1:0]    sh;
    logic [DIM_W-1:0]    dw;
    logic [DIM_W-1:0]    dh;
    logic [STRIDE_W-1:0] stride;
    logic [DIM_W-1:0]    col_q;
    logic [DIM_W-1:0]    col_r;
    logic [DIM_W-1:0]    row_q;
    logic [DIM_W-1:0]    row_r;
  } geom_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [1:0]       plane;
    logic             restart;
    logic             row_end;
    logic             new_plane;
    logic [1:0]       next_plane;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] next_row;
  } entry_t;

  typedef struct packed {
    logic               frame_end;
    logic [1:0]         plane;
    logic [COORD_W-1:0] dest_y;
    logic [COORD_W-1:0] dest_x;
    logic [PIX_W-1:0]   pixel;
  } result_t;

  typedef struct packed {
    logic             start;
    logic [DIM_W-1:0] dividend;
    logic [DIM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIM_W-1:0] quo;
    logic [DIM_W-1:0] rem;
  } div_rsp_t;

endpackage

>>> src/ynd_div.sv
module ynd_div
  import ynd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 active;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIM_W-1:0]     rem;
  logic [DIM_W-1:0]     quo;
  logic [DIM_W-1:0]     divisor;
  logic [DIM_W+1:0]     partial;
  logic                 take;
  logic [DIM_W-1:0]     rem_next;

  always_comb begin
    partial  = {1'b0, rem, quo[DIM_W-1]} - {2'b00, divisor};
    take     = ~partial[DIM_W+1];
    rem_next = take ? partial[DIM_W-1:0] : {rem[DIM_W-2:0], quo[DIM_W-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
        cnt    <= DIV_CNT_W'(DIM_W);
      end else if (active) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      quo     <= req.dividend;
      divisor <= req.divisor;
    end else if (active) begin
      rem <= rem_next;
      quo <= {quo[DIM_W-2:0], take};
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

endmodule

>>> src/ynd_cfg.sv
module ynd_cfg
  import ynd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output geom_t             luma_g,
  output geom_t             chroma_g,
  output logic              busy
);

  localparam int JOBS  = 4;
  localparam int JOB_W = $clog2(JOBS);

  typedef enum logic [2:0] {
    SU_IDLE  = 3'b001,
    SU_START = 3'b010,
    SU_WAIT  = 3'b100
  } setup_state_t;

  logic [CFG_W-1:0]    src_width;
  logic [CFG_W-1:0]    src_height;
  logic [STRIDE_W-1:0] luma_stride;
  logic [CFG_W-1:0]    chroma_stride;
  logic [CFG_W-1:0]    dst_width;
  logic [CFG_W-1:0]    dst_height;

  setup_state_t     state, state_next;
  logic [JOB_W-1:0] job, job_next;
  logic             pending, pending_next;
  logic [DIM_W-1:0] q_res [JOBS];
  logic [DIM_W-1:0] r_res [JOBS];

  logic             wr;
  logic [IDX_W-1:0] idx;
  logic [DIM_W-1:0] sw, sh, dw, dh;
  logic [DIM_W-1:0] c_sw, c_sh, c_dw, c_dh;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width     <= RST_SRC_WIDTH;
      src_height    <= RST_SRC_HEIGHT;
      luma_stride   <= RST_LUMA_STRIDE;
      chroma_stride <= RST_CHROMA_STRIDE;
      dst_width     <= RST_DST_WIDTH;
      dst_height    <= RST_DST_HEIGHT;
    end else if (wr) begin
      unique case (idx)
        REG_SRC_WIDTH:     src_width     <= pwdata[CFG_W-1:0];
        REG_SRC_HEIGHT:    src_height    <= pwdata[CFG_W-1:0];
        REG_LUMA_STRIDE:   luma_stride   <= pwdata[STRIDE_W-1:0];
        REG_CHROMA_STRIDE: chroma_stride <= pwdata[CFG_W-1:0];
        REG_DST_WIDTH:     dst_width     <= pwdata[CFG_W-1:0];
        REG_DST_HEIGHT:    dst_height    <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SRC_WIDTH:     prdata = DATA_W'(src_width);
      REG_SRC_HEIGHT:    prdata = DATA_W'(src_height);
      REG_LUMA_STRIDE:   prdata = DATA_W'(luma_stride);
      REG_CHROMA_STRIDE: prdata = DATA_W'(chroma_stride);
      REG_DST_WIDTH:     prdata = DATA_W'(dst_width);
      REG_DST_HEIGHT:    prdata = DATA_W'(dst_height);
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    sw   = (src_width > CFG_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : DIM_W'(src_width);
    sh   = (src_height > CFG_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : DIM_W'(src_height);
    dw   = (dst_width > CFG_W'(sw)) ? sw : DIM_W'(dst_width);
    dh   = (dst_height > CFG_W'(sh)) ? sh : DIM_W'(dst_height);
    c_sw = sw >> 1;
    c_sh = sh >> 1;
    c_dw = dw >> 1;
    c_dh = dh >> 1;
  end

  always_comb begin
    luma_g.sw       = sw;
    luma_g.sh       = sh;
    luma_g.dw       = dw;
    luma_g.dh       = dh;
    luma_g.stride   = (luma_stride == '0) ? STRIDE_W'(1) : luma_stride;
    luma_g.col_q    = q_res[0];
    luma_g.col_r    = r_res[0];
    luma_g.row_q    = q_res[1];
    luma_g.row_r    = r_res[1];
    chroma_g.sw     = c_sw;
    chroma_g.sh     = c_sh;
    chroma_g.dw     = c_dw;
    chroma_g.dh     = c_dh;
    chroma_g.stride = (chroma_stride == '0) ? STRIDE_W'(1) : STRIDE_W'(chroma_stride);
    chroma_g.col_q  = q_res[2];
    chroma_g.col_r  = r_res[2];
    chroma_g.row_q  = q_res[3];
    chroma_g.row_r  = r_res[3];
  end

  always_comb begin
    state_next       = state;
    job_next         = job;
    pending_next     = pending || wr;
    div_req.start    = 1'b0;
    div_req.dividend = job[0] ? (job[1] ? c_sh : sh) : (job[1] ? c_sw : sw);
    div_req.divisor  = job[0] ? (job[1] ? c_dh : dh) : (job[1] ? c_dw : dw);
    unique case (state)
      SU_IDLE: begin
        if (pending) begin
          state_next   = SU_START;
          job_next     = '0;
          pending_next = wr;
        end
      end
      SU_START: begin
        div_req.start = 1'b1;
        state_next    = SU_WAIT;
      end
      SU_WAIT: begin
        if (div_rsp.done) begin
          if (job == JOB_W'(JOBS - 1)) begin
            state_next = SU_IDLE;
          end else begin
            job_next   = job + JOB_W'(1);
            state_next = SU_START;
          end
        end
      end
      default: state_next = SU_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= SU_IDLE;
      job     <= '0;
      pending <= 1'b1;
    end else begin
      state   <= state_next;
      job     <= job_next;
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == SU_WAIT && div_rsp.done) begin
      q_res[job] <= div_rsp.quo;
      r_res[job] <= div_rsp.rem;
    end
  end

  assign busy = pending || (state != SU_IDLE);

  ynd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

>>> src/ynd_front.sv
module ynd_front
  import ynd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [PIX_W-1:0] s_tdata,
  input  logic             s_tuser,
  input  logic             busy,
  input  logic             fifo_full,
  input  geom_t            luma_g,
  input  geom_t            chroma_g,
  output logic             push,
  output entry_t           push_entry
);

  logic [1:0]       cur_plane;
  logic [COL_W-1:0] byte_column;
  logic [ROW_W-1:0] source_row;

  logic             accept;
  logic [1:0]       eff_plane;
  logic [COL_W-1:0] eff_col;
  logic [ROW_W-1:0] eff_row;
  logic [DIM_W-1:0] plane_sh;
  logic [STRIDE_W-1:0] plane_stride;
  logic [COL_W:0]   col_inc;
  logic [ROW_W:0]   row_inc;
  logic             row_end;
  logic             plane_done;
  logic [1:0]       next_plane;

  always_comb begin
    eff_plane    = s_tuser ? ((luma_g.sh != '0) ? PLANE_Y : PLANE_IDLE) : cur_plane;
    eff_col      = s_tuser ? '0 : byte_column;
    eff_row      = s_tuser ? '0 : source_row;
    plane_sh     = (eff_plane == PLANE_Y) ? luma_g.sh : chroma_g.sh;
    plane_stride = (eff_plane == PLANE_Y) ? luma_g.stride : chroma_g.stride;
    col_inc      = {1'b0, eff_col} + (COL_W+1)'(1);
    row_inc      = {1'b0, eff_row} + (ROW_W+1)'(1);
    row_end      = col_inc >= (COL_W+1)'(plane_stride);
    plane_done   = row_inc >= (ROW_W+1)'(plane_sh);
    unique case (eff_plane)
      PLANE_Y: next_plane = (chroma_g.sh != '0) ? PLANE_U : PLANE_IDLE;
      PLANE_U: next_plane = (chroma_g.sh != '0) ? PLANE_V : PLANE_IDLE;
      default: next_plane = PLANE_IDLE;
    endcase
  end

  assign s_tready = !busy && !fifo_full;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && (eff_plane != PLANE_IDLE);

  always_comb begin
    push_entry.pixel      = s_tdata;
    push_entry.plane      = eff_plane;
    push_entry.restart    = s_tuser;
    push_entry.row_end    = row_end;
    push_entry.new_plane  = row_end && plane_done;
    push_entry.next_plane = next_plane;
    push_entry.col        = eff_col;
    push_entry.next_row   = row_inc[ROW_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_plane   <= PLANE_Y;
      byte_column <= '0;
      source_row  <= '0;
    end else if (accept) begin
      if (eff_plane == PLANE_IDLE) begin
        cur_plane <= PLANE_IDLE;
      end else if (row_end) begin
        byte_column <= '0;
        if (plane_done) begin
          cur_plane  <= next_plane;
          source_row <= '0;
        end else begin
          cur_plane  <= eff_plane;
          source_row <= row_inc[ROW_W-1:0];
        end
      end else begin
        cur_plane   <= eff_plane;
        byte_column <= col_inc[COL_W-1:0];
        source_row  <= eff_row;
      end
    end
  end

endmodule

>>> src/ynd_fifo.sv
module ynd_fifo
  import ynd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wdata,
  input  logic   pop,
  output entry_t rdata,
  output logic   full,
  output logic   empty
);

  entry_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;

  assign full  = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      priority if (push && !pop) begin
        count <= count + (FIFO_AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (FIFO_AW+1)'(1);
      end else begin
        count <= count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

>>> src/ynd_back.sv
module ynd_back
  import ynd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       empty,
  input  entry_t                     head,
  output logic                       pop,
  input  geom_t                      luma_g,
  input  geom_t                      chroma_g,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [2*COORD_W+PIX_W-1:0] m_tdata,
  output logic [1:0]                 m_tuser,
  output logic                       m_tlast
);

  logic [DIM_W-1:0] out_column, out_column_next;
  logic [COL_W-1:0] next_col, next_col_next;
  logic [DIM_W-1:0] col_rem, col_rem_next;
  logic [DIM_W-1:0] out_row, out_row_next;
  logic [NSR_W-1:0] next_src_row, next_src_row_next;
  logic [DIM_W-1:0] row_rem, row_rem_next;
  logic             row_sel, row_sel_next;
  result_t          res, res_next;

  geom_t            g;
  logic [DIM_W-1:0] next_dh;
  logic [DIM_W-1:0] oc0, crem0, or0, rrem0;
  logic [COL_W-1:0] nsc0;
  logic [NSR_W-1:0] nsr0;
  logic             rsel0;
  logic             emit;
  logic [DIM_W-1:0] oc_inc, or_inc;
  logic [DIM_W:0]   col_sum, row_sum;
  logic             col_wrap, row_wrap;
  logic [DIM_W:0]   col_adj, row_adj;
  logic [COL_W-1:0] nsc_step;
  logic [NSR_W-1:0] nsr_step;
  logic [DIM_W-1:0] or1, rrem1;
  logic [NSR_W-1:0] nsr1;

  assign pop = !empty && (!m_tvalid || m_tready);

  always_comb begin
    g       = (head.plane == PLANE_Y) ? luma_g : chroma_g;
    next_dh = (head.next_plane == PLANE_Y) ? luma_g.dh : chroma_g.dh;

    if (head.restart) begin
      oc0   = '0;
      nsc0  = '0;
      crem0 = '0;
      or0   = '0;
      nsr0  = '0;
      rrem0 = '0;
      rsel0 = (g.dh != '0);
    end else begin
      oc0   = out_column;
      nsc0  = next_col;
      crem0 = col_rem;
      or0   = out_row;
      nsr0  = next_src_row;
      rrem0 = row_rem;
      rsel0 = row_sel;
    end

    emit     = rsel0 && (oc0 < g.dw) && (head.col == nsc0);
    oc_inc   = oc0 + DIM_W'(1);
    or_inc   = or0 + DIM_W'(1);

    col_sum  = {1'b0, crem0} + {1'b0, g.col_r};
    col_wrap = col_sum >= {1'b0, g.dw};
    col_adj  = col_wrap ? (col_sum - {1'b0, g.dw}) : col_sum;
    nsc_step = nsc0 + COL_W'(g.col_q) + COL_W'(col_wrap);

    row_sum  = {1'b0, rrem0} + {1'b0, g.row_r};
    row_wrap = row_sum >= {1'b0, g.dh};
    row_adj  = row_wrap ? (row_sum - {1'b0, g.dh}) : row_sum;
    nsr_step = nsr0 + NSR_W'(g.row_q) + NSR_W'(row_wrap);

    or1   = rsel0 ? or_inc : or0;
    nsr1  = rsel0 ? nsr_step : nsr0;
    rrem1 = rsel0 ? row_adj[DIM_W-1:0] : rrem0;

    if (head.row_end) begin
      out_column_next = '0;
      next_col_next   = '0;
      col_rem_next    = '0;
      if (head.new_plane) begin
        out_row_next      = '0;
        next_src_row_next = '0;
        row_rem_next      = '0;
        row_sel_next      = (head.next_plane != PLANE_IDLE) && (next_dh != '0);
      end else begin
        out_row_next      = or1;
        next_src_row_next = nsr1;
        row_rem_next      = rrem1;
        row_sel_next      = (or1 < g.dh) && (NSR_W'(head.next_row) == nsr1);
      end
    end else begin
      out_column_next   = emit ? oc_inc : oc0;
      next_col_next     = emit ? nsc_step : nsc0;
      col_rem_next      = emit ? col_adj[DIM_W-1:0] : crem0;
      out_row_next      = or0;
      next_src_row_next = nsr0;
      row_rem_next      = rrem0;
      row_sel_next      = rsel0;
    end

    res_next.pixel     = head.pixel;
    res_next.plane     = head.plane;
    res_next.dest_x    = oc0[COORD_W-1:0];
    res_next.dest_y    = or0[COORD_W-1:0];
    res_next.frame_end = (head.plane == PLANE_V) && (oc_inc == g.dw) && (or_inc == g.dh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_column   <= '0;
      next_col     <= '0;
      col_rem      <= '0;
      out_row      <= '0;
      next_src_row <= '0;
      row_rem      <= '0;
      row_sel      <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (pop) begin
        out_column   <= out_column_next;
        next_col     <= next_col_next;
        col_rem      <= col_rem_next;
        out_row      <= out_row_next;
        next_src_row <= next_src_row_next;
        row_rem      <= row_rem_next;
        row_sel      <= row_sel_next;
      end
      priority if (pop && emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end else begin
        m_tvalid <= m_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      res <= res_next;
    end
  end

  assign m_tdata = {res.dest_y, res.dest_x, res.pixel};
  assign m_tuser = res.plane;
  assign m_tlast = res.frame_end;

endmodule

>>> src/yuv420_nearest_downscale.sv
// A kept byte is written into the FIFO and, once popped, raises m_tvalid from the output register.
// Throughput: one byte per cycle while s_tready is high (no setup running, FIFO not full); dropped bytes too.
// After reset and after every register write a divider runs four 13-bit divisions
// for the luma and chroma steps; s_tready stays low meanwhile.
// Reset is synchronous and active high; registers return to a 640x480 to 320x240 setup.
module yuv420_nearest_downscale
  import ynd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [PIX_W-1:0]           s_tdata,  // pixel_byte
  input  logic                       s_tuser,  // frame_start
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [2*COORD_W+PIX_W-1:0] m_tdata,  // pixel, dest_x, dest_y
  output logic [1:0]                 m_tuser,  // plane
  output logic                       m_tlast
);

  geom_t  luma_g;
  geom_t  chroma_g;
  logic   busy;
  logic   push;
  logic   pop;
  logic   fifo_full;
  logic   fifo_empty;
  entry_t push_entry;
  entry_t head;

  assign pready = 1'b1;

  ynd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .luma_g   (luma_g),
    .chroma_g (chroma_g),
    .busy     (busy)
  );

  ynd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .busy       (busy),
    .fifo_full  (fifo_full),
    .luma_g     (luma_g),
    .chroma_g   (chroma_g),
    .push       (push),
    .push_entry (push_entry)
  );

  ynd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_entry),
    .pop   (pop),
    .rdata (head),
    .full  (fifo_full),
    .empty (fifo_empty)
  );

  ynd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (fifo_empty),
    .head     (head),
    .pop      (pop),
    .luma_g   (luma_g),
    .chroma_g (chroma_g),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

>>> src/ynd_checker.sv
`include "assert_macros.svh"

module ynd_checker
  import ynd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       psel,
  input logic       penable,
  input logic       pwrite,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [1:0] m_tuser,
  input logic       m_tlast
);

  `ASSERT_RST(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid, "stalled output dropped")
  `ASSERT_RST(a_plane_code, clk, rst, m_tvalid |-> m_tuser != PLANE_IDLE, "idle plane on output")
  `ASSERT_RST(a_last_plane, clk, rst, m_tvalid && m_tlast |-> m_tuser == PLANE_V, "tlast not in V")
  `ASSERT_ALWAYS(a_reset_setup, clk, rst |=> !s_tready, "input taken before setup after reset")
  `ASSERT_RST(a_cfg_setup, clk, rst, psel && penable && pwrite |=> !s_tready, "s_tready in setup")

endmodule

bind yuv420_nearest_downscale ynd_checker u_ynd_checker (.*);
